// ----- design/sled_pkg.sv -----
// Package with the types, codes and byte classifiers of the string literal escape decoder.
`timescale 1ns / 1ps
`default_nettype none

package sled_pkg;

  localparam int MAX_LEN_DEF = 255;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_NO_QUOTE = 3'd1;
  localparam logic [2:0] ERR_UNTERM   = 3'd2;
  localparam logic [2:0] ERR_ESC_END  = 3'd3;
  localparam logic [2:0] ERR_BAD_HEX  = 3'd4;
  localparam logic [2:0] ERR_BAD_ESC  = 3'd5;
  localparam logic [2:0] ERR_TOO_LONG = 3'd6;

  localparam logic [2:0] MODE_IDLE = 3'd0;
  localparam logic [2:0] MODE_BODY = 3'd1;
  localparam logic [2:0] MODE_ESC  = 3'd2;
  localparam logic [2:0] MODE_HEX0 = 3'd3;
  localparam logic [2:0] MODE_HEX1 = 3'd4;
  localparam logic [2:0] MODE_OCT  = 3'd5;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_7      = 8'h37;

  localparam logic [7:0] DLEN_SAT = 8'hFF;
  localparam logic [9:0] CONS_SAT = 10'h3FF;

  typedef struct packed {
    logic [7:0] src_byte;
    logic       begin_req;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [2:0] error_code;
    logic [7:0] decoded_length;
    logic [9:0] consumed_length;
    logic       last_result;
  } out_item_t;

  typedef struct packed {
    logic       vld;
    logic [1:0] kind;
    logic [7:0] data;
    logic [2:0] err;
  } act_t;

  typedef struct packed {
    logic out_vld;
    logic pend_vld;
  } buf_stat_t;

  // Returns a valid flag above the four-bit value of a hex digit.
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

  // Returns a valid flag above the byte that a simple escape stands for.
  function automatic logic [8:0] simple_esc(input logic [7:0] b);
    logic [8:0] r;
    r = 9'd0;
    case (b)
      8'h61: r = {1'b1, 8'd7};
      8'h62: r = {1'b1, 8'd8};
      8'h66: r = {1'b1, 8'd12};
      8'h6E: r = {1'b1, 8'd10};
      8'h72: r = {1'b1, 8'd13};
      8'h74: r = {1'b1, 8'd9};
      8'h76: r = {1'b1, 8'd11};
      8'h5C: r = {1'b1, 8'd92};
      8'h27: r = {1'b1, 8'd39};
      8'h3F: r = {1'b1, 8'd63};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/sled_step.sv -----
// Next-state and result logic for one source byte of the escape decoder.
`timescale 1ns / 1ps
`default_nettype none

module sled_step #(
  parameter int MAX_LEN = sled_pkg::MAX_LEN_DEF,
  parameter int DEC_W   = 8
) (
  input  sled_pkg::in_item_t  item,
  input  logic [2:0]          mode,
  input  logic [7:0]          dval,
  input  logic [1:0]          dcnt,
  input  logic [DEC_W-1:0]    dec,
  input  logic [9:0]          cons,
  output logic [1:0]          n_res,
  output sled_pkg::out_item_t res0,
  output sled_pkg::out_item_t res1,
  output logic [2:0]          mode_nxt,
  output logic [7:0]          dval_nxt,
  output logic [1:0]          dcnt_nxt,
  output logic [DEC_W-1:0]    dec_nxt,
  output logic [9:0]          cons_nxt
);
  import sled_pkg::*;

  localparam int EW = (DEC_W > 8) ? DEC_W : 8;

  act_t             a0;
  act_t             a1;
  logic             body_go;
  logic [2:0]       m;
  logic [7:0]       dv;
  logic [1:0]       dc;
  logic [DEC_W-1:0] dec_b;
  logic [DEC_W-1:0] dec_c;
  logic [9:0]       cons_a;
  logic [4:0]       hx;
  logic [8:0]       se;
  logic [7:0]       b;
  out_item_t        r_a0;
  out_item_t        r_a1;

  function automatic out_item_t pack_res(input act_t a, input logic [DEC_W-1:0] d,
                                         input logic [9:0] c);
    out_item_t r;
    logic [EW-1:0] ext;
    ext = EW'(d);
    r.kind = a.kind;
    r.data_byte = a.data;
    r.error_code = a.err;
    r.decoded_length = (ext > EW'(DLEN_SAT)) ? DLEN_SAT : ext[7:0];
    r.consumed_length = c;
    r.last_result = 1'b0;
    return r;
  endfunction

  always_comb begin
    b = item.src_byte;
    hx = hex_val(b);
    se = simple_esc(b);
    m = mode;
    dv = dval;
    dc = dcnt;
    dec_b = dec;
    cons_a = cons;
    a0 = '0;
    body_go = 1'b0;

    if (item.begin_req) begin
      dv = 8'd0;
      dc = 2'd0;
      dec_b = '0;
      cons_a = 10'd1;
      if (b != CH_QUOTE) begin
        a0 = '{vld: 1'b1, kind: KIND_ERR, data: 8'd0, err: ERR_NO_QUOTE};
        m = MODE_IDLE;
      end else begin
        m = MODE_BODY;
      end
    end else if (mode != MODE_IDLE) begin
      if (cons != CONS_SAT) begin
        cons_a = cons + 10'd1;
      end
      case (mode)
        MODE_BODY: begin
          body_go = 1'b1;
        end
        MODE_ESC: begin
          if (b == CH_QUOTE || b == CH_NUL) begin
            a0 = '{vld: 1'b1, kind: KIND_ERR, data: 8'd0, err: ERR_ESC_END};
            m = MODE_IDLE;
          end else if (b == CH_X) begin
            m = MODE_HEX0;
          end else if (b >= CH_0 && b <= CH_7) begin
            dv = {5'd0, b[2:0]};
            dc = 2'd1;
            m = MODE_OCT;
          end else if (se[8]) begin
            a0 = '{vld: 1'b1, kind: KIND_DATA, data: se[7:0], err: ERR_NONE};
            m = MODE_BODY;
          end else begin
            a0 = '{vld: 1'b1, kind: KIND_ERR, data: 8'd0, err: ERR_BAD_ESC};
            m = MODE_IDLE;
          end
        end
        MODE_HEX0: begin
          if (!hx[4]) begin
            a0 = '{vld: 1'b1, kind: KIND_ERR, data: 8'd0, err: ERR_BAD_HEX};
            m = MODE_IDLE;
          end else begin
            dv = {4'd0, hx[3:0]};
            dc = 2'd1;
            m = MODE_HEX1;
          end
        end
        MODE_HEX1: begin
          m = MODE_BODY;
          if (hx[4]) begin
            a0 = '{vld: 1'b1, kind: KIND_DATA, data: {dval[3:0], hx[3:0]}, err: ERR_NONE};
          end else begin
            a0 = '{vld: 1'b1, kind: KIND_DATA, data: {4'd0, dval[3:0]}, err: ERR_NONE};
            body_go = 1'b1;
          end
          dv = 8'd0;
          dc = 2'd0;
        end
        MODE_OCT: begin
          if (b >= CH_0 && b <= CH_7) begin
            dv = {dval[4:0], b[2:0]};
            dc = dcnt + 2'd1;
            if (dcnt == 2'd2) begin
              m = MODE_BODY;
              a0 = '{vld: 1'b1, kind: KIND_DATA, data: {dval[4:0], b[2:0]}, err: ERR_NONE};
              dv = 8'd0;
              dc = 2'd0;
            end
          end else begin
            m = MODE_BODY;
            a0 = '{vld: 1'b1, kind: KIND_DATA, data: dval, err: ERR_NONE};
            dv = 8'd0;
            dc = 2'd0;
            body_go = 1'b1;
          end
        end
        default: begin
          m = MODE_IDLE;
        end
      endcase
    end

    if (a0.vld && a0.kind == KIND_DATA) begin
      if (dec_b >= DEC_W'(MAX_LEN)) begin
        a0 = '{vld: 1'b1, kind: KIND_ERR, data: 8'd0, err: ERR_TOO_LONG};
        m = MODE_IDLE;
        body_go = 1'b0;
      end else begin
        dec_b = dec_b + DEC_W'(1);
      end
    end

    a1 = '0;
    dec_c = dec_b;
    if (body_go) begin
      if (b == CH_QUOTE) begin
        a1 = '{vld: 1'b1, kind: KIND_DONE, data: 8'd0, err: ERR_NONE};
        m = MODE_IDLE;
      end else if (b == CH_NUL) begin
        a1 = '{vld: 1'b1, kind: KIND_ERR, data: 8'd0, err: ERR_UNTERM};
        m = MODE_IDLE;
      end else if (b == CH_BSLASH) begin
        m = MODE_ESC;
      end else if (dec_b >= DEC_W'(MAX_LEN)) begin
        a1 = '{vld: 1'b1, kind: KIND_ERR, data: 8'd0, err: ERR_TOO_LONG};
        m = MODE_IDLE;
      end else begin
        a1 = '{vld: 1'b1, kind: KIND_DATA, data: b, err: ERR_NONE};
        dec_c = dec_b + DEC_W'(1);
      end
    end

    r_a0 = pack_res(a0, dec_b, cons_a);
    r_a1 = pack_res(a1, dec_c, cons_a);
    if (a0.vld) begin
      res0 = r_a0;
      res1 = r_a1;
      if (a1.vld) begin
        n_res = 2'd2;
        res1.last_result = 1'b1;
      end else begin
        n_res = 2'd1;
        res0.last_result = 1'b1;
      end
    end else begin
      res0 = r_a1;
      res0.last_result = 1'b1;
      res1 = '0;
      n_res = a1.vld ? 2'd1 : 2'd0;
    end

    mode_nxt = m;
    dval_nxt = dv;
    dcnt_nxt = dc;
    dec_nxt = dec_c;
    cons_nxt = cons_a;
  end

endmodule

`default_nettype wire

// ----- design/sled_outbuf.sv -----
// Result register with one pending slot for the second result of a byte.
`timescale 1ns / 1ps
`default_nettype none

module sled_outbuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic [1:0]          n_res,
  input  sled_pkg::out_item_t res0,
  input  sled_pkg::out_item_t res1,
  input  logic                out_stall,
  output logic                out_valid,
  output sled_pkg::out_item_t out_data,
  output sled_pkg::buf_stat_t stat
);
  import sled_pkg::*;

  logic      out_vld_r;
  logic      pend_vld_r;
  out_item_t out_r;
  out_item_t pend_r;
  logic      take;

  assign take = out_vld_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      pend_vld_r <= 1'b0;
    end else if (pend_vld_r) begin
      if (take) begin
        pend_vld_r <= 1'b0;
      end
    end else if (load && n_res != 2'd0) begin
      out_vld_r <= 1'b1;
      pend_vld_r <= (n_res == 2'd2);
    end else if (take) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_vld_r) begin
      if (take) begin
        out_r <= pend_r;
      end
    end else if (load && n_res != 2'd0) begin
      out_r <= res0;
      pend_r <= res1;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data = out_r;
  assign stat = '{out_vld: out_vld_r, pend_vld: pend_vld_r};

endmodule

`default_nettype wire

// ----- design/string_literal_escape_decoder.sv -----
// Top level of the string literal escape decoder: input register, decode state and results.
//
//   Channel   Ports                         Carries
//   input     in_valid/in_stall/in_data     one source byte and its begin mark
//   result    out_valid/out_stall/out_data  data byte, done or error with lengths
//
// One byte is taken per cycle while in_stall is low; its first result goes into the result
// register as it leaves the input register. After a byte that gives two results, the next
// byte waits in the input register while the pending slot drains via the result register.
// Reset clears the decode state to idle and empties both registers.
// A stall on the result side backs up into in_stall in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module string_literal_escape_decoder #(
  parameter int MAX_LEN = sled_pkg::MAX_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sled_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sled_pkg::out_item_t out_data
);
  import sled_pkg::*;

  localparam int DEC_W = $clog2(MAX_LEN + 1);

  logic             item_vld_r;
  in_item_t         item_r;
  logic [2:0]       mode_r;
  logic [7:0]       dval_r;
  logic [1:0]       dcnt_r;
  logic [DEC_W-1:0] dec_r;
  logic [9:0]       cons_r;
  logic [2:0]       mode_nxt;
  logic [7:0]       dval_nxt;
  logic [1:0]       dcnt_nxt;
  logic [DEC_W-1:0] dec_nxt;
  logic [9:0]       cons_nxt;
  logic [1:0]       n_res;
  out_item_t        res0;
  out_item_t        res1;
  buf_stat_t        stat;
  logic             fire;

  sled_step #(
    .MAX_LEN(MAX_LEN),
    .DEC_W  (DEC_W)
  ) u_step (
    .item    (item_r),
    .mode    (mode_r),
    .dval    (dval_r),
    .dcnt    (dcnt_r),
    .dec     (dec_r),
    .cons    (cons_r),
    .n_res   (n_res),
    .res0    (res0),
    .res1    (res1),
    .mode_nxt(mode_nxt),
    .dval_nxt(dval_nxt),
    .dcnt_nxt(dcnt_nxt),
    .dec_nxt (dec_nxt),
    .cons_nxt(cons_nxt)
  );

  sled_outbuf u_outbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (fire),
    .n_res    (n_res),
    .res0     (res0),
    .res1     (res1),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_data (out_data),
    .stat     (stat)
  );

  assign fire = item_vld_r && !stat.pend_vld &&
                (n_res == 2'd0 || !stat.out_vld || !out_stall);
  assign in_stall = item_vld_r && !fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (!in_stall) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      dval_r <= 8'd0;
      dcnt_r <= 2'd0;
      dec_r <= '0;
      cons_r <= 10'd0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      dval_r <= dval_nxt;
      dcnt_r <= dcnt_nxt;
      dec_r <= dec_nxt;
      cons_r <= cons_nxt;
    end
  end

  // The pending slot is only ever filled behind a valid result.
  a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    stat.pend_vld |-> stat.out_vld)
    else $error("pending result without a result in the output register");

  // A result that is not the last of its byte always has its partner waiting.
  a_partner_waits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_result |-> stat.pend_vld)
    else $error("first of two results shown without the second one pending");

  // Error results carry a code and other results carry none.
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.kind == KIND_ERR) == (out_data.error_code != ERR_NONE)))
    else $error("error code does not match result kind");

endmodule

`default_nettype wire

// ----- sim/string_literal_escape_decoder_test.sv -----
// Self-checking testbench for the string literal escape decoder with random pacing.
`timescale 1ns / 1ps

module string_literal_escape_decoder_test;
  import sled_pkg::*;

  localparam int MAX_LEN = MAX_LEN_DEF;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  in_item_t  source_bytes[$];
  out_item_t want_results[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int n_queued = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_data = 0;
  int n_done = 0;
  int n_err = 0;
  int n_fail = 0;

  logic [2:0]  st_mode = MODE_IDLE;
  logic [8:0]  st_digits = '0;
  logic [1:0]  st_ndig = '0;
  int unsigned st_dec = 0;
  int unsigned st_cons = 0;

  string_literal_escape_decoder #(
    .MAX_LEN(MAX_LEN)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [7:0] t;
    t = 8'd0;
    if (b >= "0" && b <= "9") begin
      t = b - "0";
      return {1'b1, t[3:0]};
    end
    if (b >= "a" && b <= "f") begin
      t = b - "a" + 8'd10;
      return {1'b1, t[3:0]};
    end
    if (b >= "A" && b <= "F") begin
      t = b - "A" + 8'd10;
      return {1'b1, t[3:0]};
    end
    return 5'd0;
  endfunction

  function automatic logic [8:0] escape_char(input logic [7:0] b);
    case (b)
      "a": return {1'b1, 8'd7};
      "b": return {1'b1, 8'd8};
      "f": return {1'b1, 8'd12};
      "n": return {1'b1, 8'd10};
      "r": return {1'b1, 8'd13};
      "t": return {1'b1, 8'd9};
      "v": return {1'b1, 8'd11};
      CH_BSLASH: return {1'b1, 8'd92};
      8'h27: return {1'b1, 8'd39};
      "?": return {1'b1, 8'd63};
      default: return 9'd0;
    endcase
  endfunction

  function automatic void push_result(input logic [1:0] kind, input logic [7:0] data,
                                      input logic [2:0] err);
    out_item_t r;
    r.kind = kind;
    r.data_byte = data;
    r.error_code = err;
    r.decoded_length = (st_dec > 255) ? DLEN_SAT : 8'(st_dec);
    r.consumed_length = (st_cons > 1023) ? CONS_SAT : 10'(st_cons);
    r.last_result = 1'b0;
    want_results.push_back(r);
  endfunction

  function automatic void raise_error(input logic [2:0] err);
    st_mode = MODE_IDLE;
    push_result(KIND_ERR, 8'd0, err);
  endfunction

  function automatic bit put_decoded(input logic [7:0] v);
    if (st_dec >= MAX_LEN) begin
      raise_error(ERR_TOO_LONG);
      return 1'b0;
    end
    st_dec++;
    push_result(KIND_DATA, v, ERR_NONE);
    return 1'b1;
  endfunction

  function automatic void body_char(input logic [7:0] b);
    if (b == CH_QUOTE) begin
      st_mode = MODE_IDLE;
      push_result(KIND_DONE, 8'd0, ERR_NONE);
    end else if (b == CH_NUL) begin
      raise_error(ERR_UNTERM);
    end else if (b == CH_BSLASH) begin
      st_mode = MODE_ESC;
    end else begin
      void'(put_decoded(b));
    end
  endfunction

  function automatic void decode_byte(input in_item_t it);
    int first;
    logic [7:0] b;
    logic [4:0] h;
    logic [8:0] s;
    bit ok;
    out_item_t r;
    first = want_results.size();
    b = it.src_byte;
    if (it.begin_req) begin
      st_digits = '0;
      st_ndig = '0;
      st_dec = 0;
      st_cons = 1;
      if (b != CH_QUOTE) raise_error(ERR_NO_QUOTE);
      else st_mode = MODE_BODY;
    end else if (st_mode != MODE_IDLE) begin
      if (st_cons < 1023) st_cons++;
      case (st_mode)
        MODE_BODY: body_char(b);
        MODE_ESC: begin
          s = escape_char(b);
          if (b == CH_QUOTE || b == CH_NUL) begin
            raise_error(ERR_ESC_END);
          end else if (b == CH_X) begin
            st_mode = MODE_HEX0;
          end else if (b >= CH_0 && b <= CH_7) begin
            st_digits = {6'd0, b[2:0]};
            st_ndig = 2'd1;
            st_mode = MODE_OCT;
          end else if (s[8]) begin
            st_mode = MODE_BODY;
            void'(put_decoded(s[7:0]));
          end else begin
            raise_error(ERR_BAD_ESC);
          end
        end
        MODE_HEX0: begin
          h = hex_digit(b);
          if (!h[4]) begin
            raise_error(ERR_BAD_HEX);
          end else begin
            st_digits = {5'd0, h[3:0]};
            st_ndig = 2'd1;
            st_mode = MODE_HEX1;
          end
        end
        MODE_HEX1: begin
          h = hex_digit(b);
          st_mode = MODE_BODY;
          if (h[4]) begin
            void'(put_decoded({st_digits[3:0], h[3:0]}));
          end else begin
            ok = put_decoded({4'd0, st_digits[3:0]});
            if (ok) body_char(b);
          end
          st_digits = '0;
          st_ndig = '0;
        end
        default: begin
          if (b >= CH_0 && b <= CH_7) begin
            st_digits = {st_digits[5:0], b[2:0]};
            st_ndig = st_ndig + 2'd1;
            if (st_ndig == 2'd3) begin
              st_mode = MODE_BODY;
              void'(put_decoded(st_digits[7:0]));
              st_digits = '0;
              st_ndig = '0;
            end
          end else begin
            st_mode = MODE_BODY;
            ok = put_decoded(st_digits[7:0]);
            st_digits = '0;
            st_ndig = '0;
            if (ok) body_char(b);
          end
        end
      endcase
    end
    if (want_results.size() > first) begin
      r = want_results.pop_back();
      r.last_result = 1'b1;
      want_results.push_back(r);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(in_data);
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (source_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= source_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_checked++;
        if (out_data.kind == KIND_DATA) n_data++;
        else if (out_data.kind == KIND_DONE) n_done++;
        else n_err++;
        if (want_results.size() == 0) begin
          n_fail++;
          $display("%0t: unexpected transfer kind=%0d data=%h err=%0d dlen=%0d clen=%0d last=%0d",
                   $time, out_data.kind, out_data.data_byte, out_data.error_code,
                   out_data.decoded_length, out_data.consumed_length, out_data.last_result);
        end else begin
          want = want_results.pop_front();
          if (out_data !== want) begin
            n_fail++;
            $display("%0t: expected kind=%0d data=%h err=%0d dlen=%0d clen=%0d last=%0d",
                     $time, want.kind, want.data_byte, want.error_code,
                     want.decoded_length, want.consumed_length, want.last_result);
            $display("%0t:   actual kind=%0d data=%h err=%0d dlen=%0d clen=%0d last=%0d",
                     $time, out_data.kind, out_data.data_byte, out_data.error_code,
                     out_data.decoded_length, out_data.consumed_length, out_data.last_result);
          end
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic push_src(input logic [7:0] b, input logic beg);
    in_item_t it;
    it.src_byte = b;
    it.begin_req = beg;
    source_bytes.push_back(it);
    n_queued++;
  endtask

  function automatic logic [7:0] pick_plain();
    logic [7:0] b;
    b = 8'($urandom_range(255, 1));
    while (b == CH_QUOTE || b == CH_BSLASH) b = 8'($urandom_range(255, 1));
    return b;
  endfunction

  function automatic logic [7:0] pick_hex();
    int v;
    v = $urandom_range(21);
    if (v < 10) return 8'("0" + v);
    if (v < 16) return 8'("a" + v - 10);
    return 8'("A" + v - 16);
  endfunction

  function automatic logic [7:0] pick_oct();
    return 8'(CH_0 + $urandom_range(7));
  endfunction

  function automatic logic [7:0] pick_escape();
    case ($urandom_range(9))
      0: return "a";
      1: return "b";
      2: return "f";
      3: return "n";
      4: return "r";
      5: return "t";
      6: return "v";
      7: return CH_BSLASH;
      8: return 8'h27;
      default: return "?";
    endcase
  endfunction

  function automatic logic [7:0] pick_nonhex();
    logic [7:0] b;
    logic [4:0] h;
    b = 8'($urandom_range(255));
    h = hex_digit(b);
    while (h[4]) begin
      b = 8'($urandom_range(255));
      h = hex_digit(b);
    end
    return b;
  endfunction

  function automatic logic [7:0] pick_bad_escape();
    logic [7:0] b;
    logic [8:0] s;
    b = 8'($urandom_range(255));
    s = escape_char(b);
    while (s[8] || b == CH_X || b == CH_QUOTE || b == CH_NUL || (b >= CH_0 && b <= CH_7)) begin
      b = 8'($urandom_range(255));
      s = escape_char(b);
    end
    return b;
  endfunction

  task automatic add_token();
    case ($urandom_range(5))
      0, 1: push_src(pick_plain(), 1'b0);
      2: begin
        push_src(CH_BSLASH, 1'b0);
        push_src(pick_escape(), 1'b0);
      end
      3: begin
        push_src(CH_BSLASH, 1'b0);
        push_src(CH_X, 1'b0);
        repeat ($urandom_range(2, 1)) push_src(pick_hex(), 1'b0);
      end
      default: begin
        push_src(CH_BSLASH, 1'b0);
        repeat ($urandom_range(3, 1)) push_src(pick_oct(), 1'b0);
      end
    endcase
  endtask

  task automatic add_broken();
    logic [7:0] b;
    case ($urandom_range(5))
      0: push_src(CH_NUL, 1'b0);
      1: begin
        push_src(CH_BSLASH, 1'b0);
        push_src($urandom_range(1) ? CH_QUOTE : CH_NUL, 1'b0);
      end
      2: begin
        push_src(CH_BSLASH, 1'b0);
        push_src(CH_X, 1'b0);
        push_src(pick_nonhex(), 1'b0);
      end
      3: begin
        push_src(CH_BSLASH, 1'b0);
        push_src(pick_bad_escape(), 1'b0);
      end
      4: begin
        b = 8'($urandom_range(255));
        while (b == CH_QUOTE) b = 8'($urandom_range(255));
        push_src(b, 1'b1);
      end
      default: push_src(CH_QUOTE, 1'b1);
    endcase
  endtask

  task automatic add_literal(input int ntok, input bit defect);
    int bad_at;
    bad_at = defect ? $urandom_range(ntok) : -1;
    push_src(CH_QUOTE, 1'b1);
    for (int i = 0; i <= ntok; i++) begin
      if (i == bad_at) add_broken();
      if (i < ntok) add_token();
    end
    if ($urandom_range(9) != 0) push_src(CH_QUOTE, 1'b0);
  endtask

  task automatic add_random(input int count);
    int start;
    int r;
    start = n_queued;
    while (n_queued - start < count) begin
      r = $urandom_range(99);
      if (r < 70) begin
        add_literal($urandom_range(12), 1'b0);
      end else if (r < 88) begin
        add_literal($urandom_range(12), 1'b1);
      end else begin
        repeat ($urandom_range(6, 1)) push_src(8'($urandom_range(255)), $urandom_range(7) == 0);
      end
    end
  endtask

  task automatic drain();
    while (source_bytes.size() != 0 || in_valid || want_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed literals: plain bytes, every escape form, short escapes ended by a quote or NUL.
    push_src("q", 1'b1);
    push_src(CH_QUOTE, 1'b1);
    push_src("A", 1'b0);
    push_src(CH_BSLASH, 1'b0);
    push_src("n", 1'b0);
    push_src(CH_BSLASH, 1'b0);
    push_src(CH_X, 1'b0);
    push_src("a", 1'b0);
    push_src("F", 1'b0);
    push_src(CH_BSLASH, 1'b0);
    push_src(CH_7, 1'b0);
    push_src(CH_7, 1'b0);
    push_src(CH_7, 1'b0);
    push_src(CH_BSLASH, 1'b0);
    push_src(CH_X, 1'b0);
    push_src("5", 1'b0);
    push_src(CH_QUOTE, 1'b0);
    push_src(CH_QUOTE, 1'b1);
    push_src(CH_BSLASH, 1'b0);
    push_src("4", 1'b0);
    push_src(CH_NUL, 1'b0);
    push_src("q", 1'b0);
    push_src(CH_QUOTE, 1'b1);
    push_src(CH_BSLASH, 1'b0);
    push_src(CH_QUOTE, 1'b0);

    // Plain body that runs past the length limit.
    push_src(CH_QUOTE, 1'b1);
    repeat (MAX_LEN + 1) push_src(pick_plain(), 1'b0);
    push_src(CH_QUOTE, 1'b0);
    drain();

    send_idle_pct = 71;
    stall_pct = 0;
    add_random(48);
    drain();

    // Octal escapes and then one hex escape, so the consumed count saturates before the length limit trips.
    send_idle_pct = 0;
    stall_pct = 71;
    push_src(CH_QUOTE, 1'b1);
    repeat (MAX_LEN) begin
      push_src(CH_BSLASH, 1'b0);
      repeat (3) push_src(pick_oct(), 1'b0);
    end
    push_src(CH_BSLASH, 1'b0);
    push_src(CH_X, 1'b0);
    push_src(pick_hex(), 1'b0);
    push_src(pick_hex(), 1'b0);
    add_random(48);
    drain();

    send_idle_pct = 18;
    stall_pct = 18;
    add_random(48);
    drain();

    repeat (10) @(posedge clk);
    $display("Sent %0d source bytes under four pacing modes, including limit and saturation cases.",
             n_accepted);
    $display("Checked %0d results: %0d data bytes, %0d done, %0d errors.",
             n_checked, n_data, n_done, n_err);
    if (n_fail == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
